>>> src/shell_sort_engine_assert.svh
// assertion macros for the shell sort engine
// expects clk and rst_n in the scope of the module that uses them
`ifndef SHELL_SORT_ENGINE_ASSERT_SVH
`define SHELL_SORT_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked only while out of reset
`define SSE_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("shell_sort_engine: check failed");
// checked on every edge, reset included
`define SSE_CHECK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("shell_sort_engine: check failed");
`else
`define SSE_CHECK(lbl, prop)
`define SSE_CHECK_ALWAYS(lbl, prop)
`endif

`endif

>>> src/sse_pkg.sv
// types and constants of the shell sort engine
// no dependencies
`default_nettype none

package sse_pkg;

  localparam int VAL_W = 16;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic                    last_res;
    logic                    overflow;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_INIT,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_WR2,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } sse_state_t;

endpackage

`default_nettype wire

>>> src/shell_sort_engine.sv
// shell sort engine top level: load, in-memory shell sort, emit
// depends on sse_pkg and shell_sort_engine_assert.svh
`default_nettype none
`include "shell_sort_engine_assert.svh"

// Takes a list of signed 16-bit values, one word per cycle on the input
// channel, until a word with last set. Up to DEPTH values are kept in an
// on-chip memory (two registered read ports, one write port); further values
// are dropped and every result of that list then carries overflow. After the
// last word the list is sorted ascending in place by shell sort with gaps
// n/2, n/4 .. 1, as a gapped insertion of compare and swap steps. Each
// compare reads both entries (ST_SORT_RD), then compares them (ST_SORT_CMP);
// a swap writes the lower entry there and the upper one in ST_SORT_WR2, since
// the memory has one write port. The sorted list then leaves word by word:
// read (ST_EMIT_RD), register (ST_EMIT_LD), hand over (ST_EMIT_HOLD), the
// final word marked last_res. The sort dominates; its compare steps grow
// about as n^1.5 for random data and n^2/4 at worst. Only one list is in
// flight: in_ready is high only while loading, and the first word of the
// next list is taken the cycle after the final result is accepted. The
// memory needs no clearing after reset; only written entries are ever read.
module shell_sort_engine #(
  parameter int DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sse_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sse_pkg::out_word_t     out_data
);
  import sse_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // element memory
  logic signed [VAL_W-1:0] mem [DEPTH];

  sse_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;   // stored elements
  logic          ovf_r, ovf_nxt;       // an element was dropped
  logic [CW-1:0] gap_r, gap_nxt;
  logic [CW-1:0] i_r, i_nxt;           // insertion position
  logic [CW-1:0] j_r, j_nxt;           // lower entry of the compare
  logic [CW-1:0] k_r, k_nxt;           // emit position
  out_word_t     out_r, out_nxt;

  // memory port controls
  logic                    we;
  logic [AW-1:0]           waddr;
  logic signed [VAL_W-1:0] wdata;
  logic                    re;
  logic [AW-1:0]           raddr0, raddr1;
  logic signed [VAL_W-1:0] rd0_r, rd1_r;

  // helpers
  logic [CW-1:0] jg_sum;      // j + gap, the upper entry
  logic [CW-1:0] i_inc;
  logic [CW-1:0] gap_half;

  assign jg_sum   = j_r + gap_r;
  assign i_inc    = i_r + 1'b1;
  assign gap_half = gap_r >> 1;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd0_r <= mem[raddr0];
      rd1_r <= mem[raddr1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gap_r <= gap_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    gap_nxt   = gap_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    out_nxt   = out_r;
    we        = 1'b0;
    waddr     = j_r[AW-1:0];
    wdata     = rd1_r;
    re        = 1'b0;
    raddr0    = j_r[AW-1:0];
    raddr1    = jg_sum[AW-1:0];
    in_ready  = 1'b0;
    out_valid = 1'b0;

    unique case (state_r) inside
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count_r != DEPTH_C) begin
            we        = 1'b1;
            waddr     = count_r[AW-1:0];
            wdata     = in_data.value;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last) begin
            state_nxt = ST_SORT_INIT;
          end
        end
      end

      ST_SORT_INIT: begin
        gap_nxt = count_r >> 1;
        i_nxt   = count_r >> 1;
        j_nxt   = '0;
        k_nxt   = '0;
        // a single element is already sorted
        state_nxt = ((count_r >> 1) == '0) ? ST_EMIT_RD : ST_SORT_RD;
      end

      ST_SORT_RD: begin
        re        = 1'b1;
        state_nxt = ST_SORT_CMP;
      end

      ST_SORT_CMP, ST_SORT_WR2: begin
        if (state_r == ST_SORT_CMP) begin
          if (rd0_r > rd1_r) begin
            // lower entry takes the smaller value, upper one follows
            we        = 1'b1;
            waddr     = j_r[AW-1:0];
            wdata     = rd1_r;
            state_nxt = ST_SORT_WR2;
          end
        end else begin
          we    = 1'b1;
          waddr = jg_sum[AW-1:0];
          wdata = rd0_r;
          if (j_r >= gap_r) begin
            // keep sinking the element down the gapped chain
            j_nxt     = j_r - gap_r;
            state_nxt = ST_SORT_RD;
          end
        end
        // chain ends: next insertion position or next gap
        if ((state_r == ST_SORT_CMP && !(rd0_r > rd1_r)) ||
            (state_r == ST_SORT_WR2 && !(j_r >= gap_r))) begin
          if (i_inc < count_r) begin
            i_nxt     = i_inc;
            j_nxt     = i_inc - gap_r;
            state_nxt = ST_SORT_RD;
          end else begin
            gap_nxt   = gap_half;
            i_nxt     = gap_half;
            j_nxt     = '0;
            state_nxt = (gap_half == '0) ? ST_EMIT_RD : ST_SORT_RD;
          end
        end
      end

      ST_EMIT_RD: begin
        re        = 1'b1;
        raddr0    = k_r[AW-1:0];
        state_nxt = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        out_nxt.sorted_value = rd0_r;
        out_nxt.last_res     = ((k_r + 1'b1) == count_r);
        out_nxt.overflow     = ovf_r;
        state_nxt            = ST_EMIT_HOLD;
      end

      ST_EMIT_HOLD: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (out_r.last_res) begin
            // list done, start a fresh one
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: state_nxt = ST_LOAD;
    endcase
  end

  assign out_data = out_r;

  // loading and emitting never overlap
  `SSE_CHECK_ALWAYS(a_one_side, !(out_valid && in_ready))
  // store fill never passes its depth
  `SSE_CHECK(a_count_bound, count_r <= DEPTH_C)
  // second swap write only right after a compare
  `SSE_CHECK(a_wr2_after_cmp, state_r == ST_SORT_WR2 |-> $past(state_r) == ST_SORT_CMP)
  // compares stay inside the stored list
  `SSE_CHECK(a_cmp_in_list, state_r == ST_SORT_RD |-> gap_r != '0 && jg_sum < count_r)
  // taking the final word reopens the input
  `SSE_CHECK(a_reopen, out_valid && out_ready && out_data.last_res |=> in_ready)

endmodule

`default_nettype wire

>>> sim/tb.sv
// self-checking testbench for shell_sort_engine: sends lists of signed words and
// checks every sorted word against its own shell sort of the same list
// depends on sse_pkg and the shell_sort_engine rtl
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sse_pkg::*;

  localparam int DEPTH = 64;

  // value mixes for list contents
  typedef enum int {
    VAL_WIDE,
    VAL_NARROW,
    VAL_EDGE,
    VAL_MIXED
  } val_style_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  // idle chances in percent, changed per phase by the main sequence
  int unsigned send_idle_pct = 24;
  int unsigned recv_idle_pct = 83;

  // long receiver hold-off: main bumps the sequence number, receiver then counts hold_req_cycles down
  int unsigned hold_req_cycles = 0;
  int unsigned hold_req_seq = 0;

  int unsigned errors = 0;
  int unsigned words_sent = 0;

  // predictor state: the list being collected and the sorted words still owed
  logic signed [VAL_W-1:0] list_vals [DEPTH];
  int                      list_len = 0;
  bit                      list_dropped = 1'b0;
  out_word_t               sorted_q [$];

  shell_sort_engine #(
    .DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous ceiling, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // one accepted input word: store or drop it, and on the list end sort and
  // queue the whole sorted list
  function automatic void absorb_word(in_word_t w);
    logic signed [VAL_W-1:0] tmp;
    int gap;
    int j;
    out_word_t r;
    if (list_len < DEPTH) begin
      list_vals[list_len] = w.value;
      list_len++;
    end else begin
      list_dropped = 1'b1;
    end
    if (w.last) begin
      // halving gaps, gapped insertion by compare and swap
      for (gap = list_len / 2; gap > 0; gap = gap / 2) begin
        for (int i = gap; i < list_len; i++) begin
          j = i - gap;
          while (j >= 0) begin
            if (list_vals[j] <= list_vals[j + gap]) break;
            tmp = list_vals[j];
            list_vals[j] = list_vals[j + gap];
            list_vals[j + gap] = tmp;
            j -= gap;
          end
        end
      end
      for (int k = 0; k < list_len; k++) begin
        r.sorted_value = list_vals[k];
        r.last_res     = (k == list_len - 1);
        r.overflow     = list_dropped;
        sorted_q.push_back(r);
      end
      list_len     = 0;
      list_dropped = 1'b0;
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value(val_style_t style);
    val_style_t s;
    s = style;
    if (s == VAL_MIXED) s = val_style_t'($urandom_range(2));
    case (s)
      VAL_NARROW: return VAL_W'($urandom_range(8) - 4);  // many equal values
      VAL_EDGE: begin
        case ($urandom_range(4))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return -16'sd1;
          3: return 16'sd0;
          default: return 16'sd1;
        endcase
      end
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // offer one word, hold it until taken, then feed the predictor
  task automatic send_word(logic signed [VAL_W-1:0] v, logic is_last);
    in_word_t w;
    w.value = v;
    w.last  = is_last;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    absorb_word(w);
    words_sent++;
  endtask

  task automatic send_list(int len, val_style_t style);
    for (int k = 0; k < len; k++) send_word(pick_value(style), k == len - 1);
  endtask

  // drop valid, wait for every owed word, then idle quietly before returning
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver: random ready, or held low for a requested stretch
  initial begin
    int unsigned hold_seen_seq;
    int unsigned hold_left;
    hold_seen_seq = 0;
    hold_left     = 0;
    out_ready     = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen_seq != hold_req_seq) begin
        hold_seen_seq = hold_req_seq;
        hold_left     = hold_req_cycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result checker: each taken word against the oldest owed word
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sorted_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word value %0d", out_data.sorted_value));
      end else begin
        want = sorted_q.pop_front();
        if (out_data.sorted_value !== want.sorted_value)
          report_mismatch($sformatf("sorted_value %0d, want %0d",
                                    out_data.sorted_value, want.sorted_value));
        if (out_data.last_res !== want.last_res)
          report_mismatch($sformatf("last_res %b, want %b",
                                    out_data.last_res, want.last_res));
        if (out_data.overflow !== want.overflow)
          report_mismatch($sformatf("overflow %b, want %b",
                                    out_data.overflow, want.overflow));
      end
    end
  end

  // extremes, one-word lists, equal values, reversed and short lists
  task automatic test_directed();
    send_word(16'sh8000, 1'b1);
    send_word(16'sh7fff, 1'b1);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sd0, 1'b0);
    send_word(-16'sd1, 1'b0);
    send_word(16'sd1, 1'b1);
    send_word(16'sd5, 1'b0);
    send_word(-16'sd5, 1'b0);
    send_word(16'sd5, 1'b0);
    send_word(16'sd5, 1'b1);
    for (int k = 0; k < 6; k++) send_word(VAL_W'(40 - 10 * k), k == 5);
    send_word(-16'sd2, 1'b0);
    send_word(16'sd2, 1'b1);
  endtask

  // store exactly full, then full with the end word dropped, then well past full
  task automatic test_full_store();
    send_list(DEPTH, VAL_WIDE);
    send_list(DEPTH + 1, VAL_MIXED);
    send_list(DEPTH + 6, VAL_NARROW);
  endtask

  // mostly short lists, some long ones and the odd overflowing one
  task automatic test_random_lists(int unsigned n_words);
    int unsigned stop_at;
    int          len;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      case ($urandom_range(29)) inside
        0:       len = $urandom_range(DEPTH + 4, DEPTH + 1);
        1, 2, 3: len = $urandom_range(DEPTH, 13);
        default: len = $urandom_range(12, 1);
      endcase
      send_list(len, val_style_t'($urandom_range(3)));
    end
  endtask

  // receiver holds off long enough for the first list to sort and park, while
  // the next list keeps being offered against a closed input
  task automatic test_backpressure();
    hold_req_cycles = 500;
    hold_req_seq++;
    send_list(10, VAL_WIDE);
    send_list(6, VAL_MIXED);
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // phase one: sender idles a little, receiver a lot
    test_directed();
    test_random_lists(90);
    wait_drained();

    // phase two: the other way round
    send_idle_pct = 83;
    recv_idle_pct = 24;
    test_full_store();
    test_random_lists(80);
    wait_drained();

    // phase three: no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_lists(90);
    wait_drained();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
